// ===== rtl/ftrg_pkg.sv =====
// Shared types and constants for the frame time resolution governor.
package ftrg_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_TH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAISE_TH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_FRAMES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAISE_FRAMES= 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE   = 3'd5;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic [31:0] RST_DROP_TH      = 32'd15833333;
    localparam logic [31:0] RST_RAISE_TH     = 32'd12500000;
    localparam logic [7:0]  RST_DROP_FRAMES  = 8'd3;
    localparam logic [7:0]  RST_RAISE_FRAMES = 8'd10;
    localparam logic [15:0] RST_GAIN         = 16'd6554;
    localparam logic [15:0] RST_MIN_SCALE    = 16'd16384;

    // Field widths.
    localparam int FRAME_W = 32;
    localparam int SCALE_W = 16;
    localparam int CNT_W   = 8;

    // Scale of 1.0 in Q1.15 and the working scale width (scale plus a raise step).
    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd32768;
    localparam int WORK_W = 18;

    // Width of gain times scale, ratio accumulator and its saturation level.
    localparam int G_W   = 31;
    localparam int ACC_W = 34;
    localparam logic [ACC_W-1:0] RATIO_SAT = 34'h2_0000_0000;

    // Square root datapath.
    localparam int SQ_W       = 35;
    localparam int STEP_W     = 17;
    localparam int ROOT_STEPS = 17;
    localparam logic [SQ_W-1:0] ROOT_BIT_TOP = 35'h1_0000_0000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_MUL,
        ST_DIV,
        ST_FRAC,
        ST_RINIT,
        ST_ROOT,
        ST_APPLY,
        ST_DONE
    } t_state;

    // Which adjustment the shared unit is working on.
    typedef enum logic {
        ADJ_DROP,
        ADJ_RAISE
    } t_adj;

endpackage

// ===== rtl/ftrg_if.sv =====
// Handshake channel interfaces for frame times, results and configuration.
interface ftrg_in_if import ftrg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_time_ns;

    modport source (output valid, output frame_time_ns, input ready);
    modport sink   (input valid, input frame_time_ns, output ready);
endinterface

interface ftrg_out_if import ftrg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCALE_W-1:0] new_scale;
    logic               dropped;
    logic               raised;

    modport source (output valid, output new_scale, output dropped, output raised,
                    input ready);
    modport sink   (input valid, input new_scale, input dropped, input raised,
                    output ready);
endinterface

interface ftrg_cfg_if import ftrg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/frame_time_resolution_governor_top.sv =====
// Top level of the frame time resolution governor.
//
//  Channel   Direction  Payload
//  i_in      in         frame_time_ns[31:0]
//  o_out     out        new_scale[15:0], dropped, raised
//  i_cfg     in         index[2:0], data[31:0]
//
// A frame with no adjustment passes through the idle, classify and done
// states to the output register. Each adjustment that fires runs the shared
// divide and square root unit: multiply, restoring divide, ratio over the gain
// bits, integer square root and apply; a drop runs before a raise. Reset is
// synchronous and restores the register defaults and a scale of 1.0. Input is
// taken only in the idle state; a finished result waits in the output register
// while the next frame starts.
module frame_time_resolution_governor_top
    import ftrg_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ftrg_in_if.sink    i_in,
    ftrg_out_if.source o_out,
    ftrg_cfg_if.sink   i_cfg
);

    localparam int W  = TIME_WIDTH;
    localparam int SW = ((W > ACC_W) ? W : ACC_W) + 1;
    localparam int CW = ($clog2(W) > 5) ? $clog2(W) : 5;

    // Configuration registers.
    logic [31:0]        r_drop_th, r_raise_th;
    logic [CNT_W-1:0]   r_drop_frames, r_raise_frames;
    logic [15:0]        r_gain;
    logic [SCALE_W-1:0] r_min_scale;

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    t_adj               r_adj, n_adj;
    logic [W-1:0]       r_t, n_t;
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [CNT_W-1:0]   r_slow, n_slow, r_fast, n_fast;
    logic [WORK_W-1:0]  r_work, n_work;
    logic               r_fire_d, n_fire_d, r_fire_r, n_fire_r;
    logic [W-1:0]       r_num, n_num, r_den, n_den, r_rem, n_rem, r_rr, n_rr;
    logic [G_W-1:0]     r_g, n_g;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_sub, n_sub;
    logic [SQ_W-1:0]    r_v, n_v, r_res, n_res, r_b, n_b;
    logic               r_out_valid, n_out_valid;
    logic [SCALE_W-1:0] r_out_scale, n_out_scale;
    logic               r_out_dropped, n_out_dropped, r_out_raised, n_out_raised;

    // Combinational helpers.
    logic [W-1:0]       dth, rth;
    logic               slow, fast, fire_d, fire_r;
    logic [CNT_W-1:0]   slow_inc, fast_inc;
    logic [31:0]        prod;
    logic [W:0]         rem_sh, rr2, rr3;
    logic [SW-1:0]      acc2, acc3;
    logic [SQ_W-1:0]    trial;
    logic [STEP_W-1:0]  step;
    logic [WORK_W-1:0]  clamped;

    assign dth = W'(r_drop_th);
    assign rth = W'(r_raise_th);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.new_scale = r_out_scale;
    assign o_out.dropped   = r_out_dropped;
    assign o_out.raised    = r_out_raised;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_th      <= RST_DROP_TH;
            r_raise_th     <= RST_RAISE_TH;
            r_drop_frames  <= RST_DROP_FRAMES;
            r_raise_frames <= RST_RAISE_FRAMES;
            r_gain         <= RST_GAIN;
            r_min_scale    <= RST_MIN_SCALE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DROP_TH:      r_drop_th      <= i_cfg.data;
                REG_RAISE_TH:     r_raise_th     <= i_cfg.data;
                REG_DROP_FRAMES:  r_drop_frames  <= i_cfg.data[CNT_W-1:0];
                REG_RAISE_FRAMES: r_raise_frames <= i_cfg.data[CNT_W-1:0];
                REG_GAIN:         r_gain         <= i_cfg.data[15:0];
                REG_MIN_SCALE:    r_min_scale    <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_ONE;
            r_slow      <= '0;
            r_fast      <= '0;
            r_out_valid <= 1'b0;
            r_adj       <= ADJ_DROP;
            r_fire_d    <= 1'b0;
            r_fire_r    <= 1'b0;
            r_cnt       <= '0;
            r_sub       <= 1'b0;
        end else begin
            r_scale     <= n_scale;
            r_slow      <= n_slow;
            r_fast      <= n_fast;
            r_out_valid <= n_out_valid;
            r_adj       <= n_adj;
            r_fire_d    <= n_fire_d;
            r_fire_r    <= n_fire_r;
            r_cnt       <= n_cnt;
            r_sub       <= n_sub;
        end
        r_t           <= n_t;
        r_work        <= n_work;
        r_num         <= n_num;
        r_den         <= n_den;
        r_rem         <= n_rem;
        r_rr          <= n_rr;
        r_g           <= n_g;
        r_acc         <= n_acc;
        r_v           <= n_v;
        r_res         <= n_res;
        r_b           <= n_b;
        r_out_scale   <= n_out_scale;
        r_out_dropped <= n_out_dropped;
        r_out_raised  <= n_out_raised;
    end

    // Next state and datapath for the shared divide and square root unit.
    always_comb begin
        n_state       = r_state;
        n_adj         = r_adj;
        n_t           = r_t;
        n_scale       = r_scale;
        n_slow        = r_slow;
        n_fast        = r_fast;
        n_work        = r_work;
        n_fire_d      = r_fire_d;
        n_fire_r      = r_fire_r;
        n_num         = r_num;
        n_den         = r_den;
        n_rem         = r_rem;
        n_rr          = r_rr;
        n_g           = r_g;
        n_acc         = r_acc;
        n_cnt         = r_cnt;
        n_sub         = r_sub;
        n_v           = r_v;
        n_res         = r_res;
        n_b           = r_b;
        n_out_valid   = r_out_valid;
        n_out_scale   = r_out_scale;
        n_out_dropped = r_out_dropped;
        n_out_raised  = r_out_raised;

        slow     = r_t > dth;
        fast     = r_t < rth;
        slow_inc = (r_slow != {CNT_W{1'b1}}) ? r_slow + CNT_W'(1) : r_slow;
        fast_inc = (r_fast != {CNT_W{1'b1}}) ? r_fast + CNT_W'(1) : r_fast;
        fire_d   = slow && (slow_inc >= r_drop_frames);
        fire_r   = fast && (fast_inc >= r_raise_frames);
        prod     = 32'(r_gain) * 32'(r_work[SCALE_W-1:0]);
        rem_sh   = {r_rem, r_num[W-1]};
        rr2      = {r_rr, 1'b0};
        rr3      = {1'b0, r_rr} + {1'b0, r_rem};
        acc2     = SW'(r_acc) + SW'(r_acc);
        acc3     = SW'(r_acc) + SW'(r_num);
        trial    = r_res + r_b;
        step     = r_res[STEP_W-1:0];
        clamped  = r_work;

        // The result register drains whenever the sink takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_t     = W'(i_in.frame_time_ns);
                    n_state = ST_CLASS;
                end
            end

            // Update the run counters and pick the first adjustment.
            ST_CLASS: begin
                n_slow   = (slow && !fire_d) ? slow_inc : '0;
                n_fast   = (fast && !fire_r) ? fast_inc : '0;
                n_fire_d = fire_d;
                n_fire_r = fire_r;
                n_work   = WORK_W'(r_scale);
                if (fire_d) begin
                    n_adj   = ADJ_DROP;
                    n_num   = r_t - dth;
                    n_den   = dth;
                    n_state = ST_MUL;
                end else if (fire_r) begin
                    n_adj   = ADJ_RAISE;
                    n_num   = rth - r_t;
                    n_den   = rth;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end

            // Gain times scale; a zero divisor saturates the ratio at once unless the product is zero.
            ST_MUL: begin
                n_g   = prod[G_W-1:0];
                n_rem = '0;
                n_rr  = '0;
                n_cnt = CW'(W - 1);
                if (r_den == '0) begin
                    n_acc   = (prod == '0) ? '0 : RATIO_SAT;
                    n_state = ST_RINIT;
                end else begin
                    n_acc   = '0;
                    n_state = ST_DIV;
                end
            end

            // Restoring division of the difference by the threshold.
            ST_DIV: begin
                if (rem_sh >= {1'b0, r_den}) begin
                    n_rem = W'(rem_sh - {1'b0, r_den});
                    n_num = {r_num[W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[W-1:0];
                    n_num = {r_num[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_cnt   = CW'(G_W - 1);
                    n_sub   = 1'b0;
                    n_state = ST_FRAC;
                end
            end

            // Gain bits, most significant first: double, then add quotient and
            // remainder, keeping the remainder below the threshold.
            ST_FRAC: begin
                if (!r_sub) begin
                    if (rr2 >= {1'b0, r_den}) begin
                        n_rr = W'(rr2 - {1'b0, r_den});
                        acc2 = acc2 + SW'(1);
                    end else begin
                        n_rr = rr2[W-1:0];
                    end
                    n_acc = (acc2 >= SW'(RATIO_SAT)) ? RATIO_SAT : acc2[ACC_W-1:0];
                    n_sub = 1'b1;
                end else begin
                    if (r_g[G_W-1]) begin
                        if (rr3 >= {1'b0, r_den}) begin
                            n_rr = W'(rr3 - {1'b0, r_den});
                            acc3 = acc3 + SW'(1);
                        end else begin
                            n_rr = rr3[W-1:0];
                        end
                        n_acc = (acc3 >= SW'(RATIO_SAT)) ? RATIO_SAT : acc3[ACC_W-1:0];
                    end
                    n_g   = {r_g[G_W-2:0], 1'b0};
                    n_sub = 1'b0;
                    n_cnt = r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        n_state = ST_RINIT;
                    end
                end
            end

            // The drop uses half the ratio, the raise a quarter.
            ST_RINIT: begin
                n_v     = (r_adj == ADJ_DROP) ? SQ_W'(r_acc >> 1) : SQ_W'(r_acc >> 2);
                n_res   = '0;
                n_b     = ROOT_BIT_TOP;
                n_cnt   = CW'(ROOT_STEPS - 1);
                n_state = ST_ROOT;
            end

            // Integer square root, one result bit per cycle.
            ST_ROOT: begin
                if (r_v >= trial) begin
                    n_v   = r_v - trial;
                    n_res = (r_res >> 1) + r_b;
                end else begin
                    n_res = r_res >> 1;
                end
                n_b   = r_b >> 2;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_APPLY;
                end
            end

            // Apply the step; a drop may be followed by a raise.
            ST_APPLY: begin
                if (r_adj == ADJ_DROP) begin
                    n_work = ({1'b0, step} >= r_work) ? '0 : r_work - WORK_W'(step);
                    if (r_fire_r) begin
                        n_adj   = ADJ_RAISE;
                        n_num   = rth - r_t;
                        n_den   = rth;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_work  = r_work + WORK_W'(step);
                    n_state = ST_DONE;
                end
            end

            // Clamp and hand the result to the output register.
            ST_DONE: begin
                if (r_work < WORK_W'(r_min_scale)) begin
                    clamped = WORK_W'(r_min_scale);
                end
                if (clamped > WORK_W'(SCALE_ONE)) begin
                    clamped = WORK_W'(SCALE_ONE);
                end
                if (!r_out_valid || o_out.ready) begin
                    n_scale       = clamped[SCALE_W-1:0];
                    n_out_scale   = clamped[SCALE_W-1:0];
                    n_out_dropped = r_fire_d;
                    n_out_raised  = r_fire_r;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== dv/tb_frame_time_resolution_governor_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the frame time resolution governor top level.
module tb_frame_time_resolution_governor_top;
    import ftrg_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int RANDOM_FRAMES = 1400;
    localparam int TAIL_CYCLES   = 300;
    localparam int LONG_HOLD     = 400;

    // Indexes past the register file; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [SCALE_W-1:0] new_scale;
        logic               dropped;
        logic               raised;
    } t_scale_result;

    typedef enum int {
        FT_SLOW,
        FT_FAST,
        FT_MID,
        FT_NOISE,
        FT_EDGE
    } t_frame_kind;

    // Tracks the governor state and compares results in arrival order.
    class t_scale_scoreboard;
        logic [31:0]   drop_th;
        logic [31:0]   raise_th;
        logic [7:0]    drop_need;
        logic [7:0]    raise_need;
        logic [15:0]   gain_q16;
        logic [15:0]   floor_scale;
        int unsigned   cur_scale;
        int unsigned   slow_run;
        int unsigned   fast_run;
        t_scale_result expected_scales[$];
        int            errors;

        function new();
            drop_th     = RST_DROP_TH;
            raise_th    = RST_RAISE_TH;
            drop_need   = RST_DROP_FRAMES;
            raise_need  = RST_RAISE_FRAMES;
            gain_q16    = RST_GAIN;
            floor_scale = RST_MIN_SCALE;
            cur_scale   = 32'(SCALE_ONE);
            slow_run    = 0;
            fast_run    = 0;
            errors      = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_DROP_TH:      drop_th     = value;
                REG_RAISE_TH:     raise_th    = value;
                REG_DROP_FRAMES:  drop_need   = value[7:0];
                REG_RAISE_FRAMES: raise_need  = value[7:0];
                REG_GAIN:         gain_q16    = value[15:0];
                REG_MIN_SCALE:    floor_scale = value[15:0];
                default: ;
            endcase
        endfunction

        // Truncated g * num / den, saturated; a zero divisor saturates unless g or num is zero.
        function logic [63:0] ratio_q31(logic [63:0] g, logic [63:0] num,
                                        logic [63:0] den);
            logic [63:0] quot;
            if (g == 0 || num == 0) return 64'd0;
            if (den == 0) return 64'(RATIO_SAT);
            quot = (g * num) / den;
            return (quot > 64'(RATIO_SAT)) ? 64'(RATIO_SAT) : quot;
        endfunction

        // Floor of the square root, one result bit at a time.
        function logic [63:0] root_q15(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] cand;
            root = 64'd0;
            for (int b = 17; b >= 0; b--) begin
                cand = root | (64'd1 << b);
                if (cand * cand <= v) root = cand;
            end
            return root;
        endfunction

        // Predicts the result of one accepted frame and queues it.
        function void note_frame(logic [31:0] t);
            logic [63:0]   s;
            logic [63:0]   g;
            logic [63:0]   pct;
            logic [63:0]   step;
            t_scale_result res;
            s   = 64'(cur_scale);
            res = '0;

            // Slow frames lower the scale once the run is long enough.
            if (t > drop_th) begin
                if (slow_run < 255) slow_run++;
                if (slow_run >= drop_need) begin
                    g    = 64'(gain_q16) * s;
                    pct  = ratio_q31(g, 64'(t) - 64'(drop_th), 64'(drop_th)) >> 1;
                    step = root_q15(pct);
                    s    = (step >= s) ? 64'd0 : s - step;
                    slow_run = 0;
                    res.dropped = 1'b1;
                end
            end else begin
                slow_run = 0;
            end

            // Fast frames raise the scale, starting from the dropped value.
            if (t < raise_th) begin
                if (fast_run < 255) fast_run++;
                if (fast_run >= raise_need) begin
                    g    = 64'(gain_q16) * s;
                    pct  = ratio_q31(g, 64'(raise_th) - 64'(t), 64'(raise_th)) >> 2;
                    step = root_q15(pct);
                    s    = s + step;
                    if (s > 64'hF_FFFF) s = 64'hF_FFFF;
                    fast_run = 0;
                    res.raised = 1'b1;
                end
            end else begin
                fast_run = 0;
            end

            // The floor is applied first, then the ceiling of 1.0.
            if (s < 64'(floor_scale)) s = 64'(floor_scale);
            if (s > 64'(SCALE_ONE)) s = 64'(SCALE_ONE);
            cur_scale = 32'(s);
            res.new_scale = s[15:0];
            expected_scales.push_back(res);
        endfunction

        function void check_result(logic [SCALE_W-1:0] sc, logic dr, logic rs);
            t_scale_result exp_res;
            if (expected_scales.size() == 0) begin
                $error("result transfer with no frame outstanding, new_scale %0d", sc);
                errors++;
                return;
            end
            exp_res = expected_scales.pop_front();
            if (sc !== exp_res.new_scale) begin
                $error("new_scale mismatch: expected %0d, actual %0d",
                       exp_res.new_scale, sc);
                errors++;
            end
            if (dr !== exp_res.dropped) begin
                $error("dropped mismatch: expected %0d, actual %0d", exp_res.dropped, dr);
                errors++;
            end
            if (rs !== exp_res.raised) begin
                $error("raised mismatch: expected %0d, actual %0d", exp_res.raised, rs);
                errors++;
            end
        endfunction

        function int pending();
            return expected_scales.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    t_scale_scoreboard sb;
    int                frames_sent;
    int                holds_done;
    bit                quiet_in;
    bit                quiet_out;
    int unsigned       cycle_count = 0;

    ftrg_in_if  in_if ();
    ftrg_out_if out_if ();
    ftrg_cfg_if cfg_if ();

    frame_time_resolution_governor_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_cycles(bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Frame count register values: mostly small, sometimes up to the maximum.
    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return $urandom_range(0, 6);
        if (roll < 9) return $urandom_range(7, 30);
        return $urandom_range(31, 255);
    endfunction

    // Frame time of the given class relative to the current thresholds.
    function automatic logic [31:0] pick_frame(t_frame_kind kind);
        longint unsigned d;
        longint unsigned r;
        longint unsigned lim;
        longint unsigned lo;
        longint unsigned hi;
        d = 64'(sb.drop_th);
        r = 64'(sb.raise_th);
        case (kind)
            FT_SLOW: begin
                if (d == 64'hFFFF_FFFF) return $urandom();
                lim = 64'hFFFF_FFFF - d - 1;
                if ($urandom_range(0, 1) && d / 4 < lim) lim = d / 4;
                return 32'(d + 1 + $urandom_range(0, 32'(lim)));
            end
            FT_FAST: begin
                if (r == 0) return $urandom();
                if ($urandom_range(0, 1)) return 32'(r - 1 - $urandom_range(0, 32'((r - 1) / 8)));
                return $urandom_range(0, 32'(r - 1));
            end
            FT_MID: begin
                lo = (r <= d) ? r : d + 1;
                hi = (r <= d) ? d : r - 1;
                if (lo > hi) return $urandom();
                return $urandom_range(32'(lo), 32'(hi));
            end
            FT_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return 32'd0;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'(d);
                    3: return 32'(d + 1);
                    4: return 32'(r);
                    default: return 32'(r - 1);
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Offers one frame after a random gap and waits for its transfer.
    task automatic send_frame(input logic [31:0] t);
        int gap;
        gap = idle_cycles(quiet_in);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.frame_time_ns <= t;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_frame(t);
        frames_sent++;
    endtask

    // Stops offering frames and waits until every result has come back.
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.apply_reg(idx, value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] d, input logic [31:0] r,
                              input logic [31:0] dn, input logic [31:0] rn,
                              input logic [31:0] g, input logic [31:0] m);
        write_reg(REG_DROP_TH, d);
        write_reg(REG_RAISE_TH, r);
        write_reg(REG_DROP_FRAMES, dn);
        write_reg(REG_RAISE_FRAMES, rn);
        write_reg(REG_GAIN, g);
        write_reg(REG_MIN_SCALE, m);
    endtask

    // One random setting followed by bursts of slow, fast and mixed frames.
    task automatic random_phase(input int n);
        logic [31:0] d;
        logic [31:0] r;
        logic [31:0] dn;
        logic [31:0] rn;
        logic [31:0] g;
        logic [31:0] m;
        t_frame_kind kind;
        int          roll;
        int          left;
        int          len;

        case ($urandom_range(0, 9))
            0: d = $urandom();
            1: begin
                roll = $urandom_range(0, 2);
                d = (roll == 0) ? 32'd0 : (roll == 1) ? 32'd1 : 32'hFFFF_FFFF;
            end
            default: d = $urandom_range(100_000, 50_000_000);
        endcase
        case ($urandom_range(0, 9))
            0: r = $urandom();
            1: r = d + $urandom_range(1, 1_000_000);
            2: r = d;
            default: r = d - d / $urandom_range(2, 10);
        endcase
        dn = pick_count();
        rn = pick_count();
        if ($urandom_range(0, 1)) dn |= $urandom() & 32'hFFFF_FF00;
        if ($urandom_range(0, 1)) rn |= $urandom() & 32'hFFFF_FF00;
        case ($urandom_range(0, 9))
            0: g = 32'd0;
            1: g = 32'd65535;
            default: g = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 1)) g |= $urandom() & 32'hFFFF_0000;
        case ($urandom_range(0, 19))
            0, 1: m = 32'd0;
            2, 3: m = 32'd32768;
            4: m = $urandom_range(32769, 65535);
            default: m = $urandom_range(0, 32768);
        endcase
        set_config(d, r, dn, rn, g, m);
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());

        quiet_in  = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);

        // Bursts build up runs; the odd stray frame breaks them.
        left = n;
        while (left > 0) begin
            roll = $urandom_range(0, 9);
            kind = (roll < 4) ? FT_SLOW : (roll < 7) ? FT_FAST :
                   (roll == 7) ? FT_MID : (roll == 8) ? FT_NOISE : FT_EDGE;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
            if (len > left) len = left;
            repeat (len) begin
                if ($urandom_range(0, 9) == 0)
                    send_frame(pick_frame(t_frame_kind'($urandom_range(0, 4))));
                else
                    send_frame(pick_frame(kind));
            end
            left -= len;
        end
    endtask

    // Result side: random back-pressure, two long holds, and checking.
    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ((holds_done == 0 && frames_sent >= 60) ||
                (holds_done == 1 && frames_sent >= 900)) begin
                stall_left = LONG_HOLD;
                holds_done++;
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                stall_left = idle_cycles(quiet_out);
            end
            @(posedge i_clk);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.new_scale, out_if.dropped, out_if.raised);
        end
    end

    // Reset, directed settings, then random phases.
    initial begin
        int total;
        int n;
        sb                  = new();
        frames_sent         = 0;
        holds_done          = 0;
        quiet_in            = 1'b0;
        quiet_out           = 1'b0;
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.frame_time_ns = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: saturated drop, ties at both thresholds, normal drop.
        send_frame(32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd0);
        send_frame(32'd15833333);
        send_frame(32'd12500000);
        send_frame(32'd20000000);
        send_frame(32'd20000000);
        send_frame(32'd20000000);

        // Overlapping thresholds, zero frame counts, full gain, zero floor.
        settle();
        set_config(32'd1000, 32'd5000, 32'hFFFF_FF00, 32'h0000_0100, 32'd65535, 32'd0);
        send_frame(32'd3000);
        send_frame(32'd1001);
        send_frame(32'd4999);
        send_frame(32'd0);
        send_frame(32'h8000_0000);

        // Zero drop threshold, floor above one, writes to unused indexes.
        settle();
        set_config(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd32768, 32'd65535);
        write_reg(REG_SPARE_A, 32'd123);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        send_frame(32'd0);
        send_frame(32'd1);
        send_frame(32'h5555_5555);
        send_frame(32'hAAAA_AAAA);

        // Maximum thresholds, zero gain, floor at one, maximum drop count.
        settle();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255, 32'd2, 32'd0, 32'd32768);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFE);
        send_frame(32'hFFFF_FFFE);
        send_frame(32'd0);

        total = 0;
        while (total < RANDOM_FRAMES) begin
            n = $urandom_range(60, 160);
            if (n > RANDOM_FRAMES - total) n = RANDOM_FRAMES - total;
            settle();
            random_phase(n);
            total += n;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== frame_time_resolution_governor_top.f =====
rtl/ftrg_pkg.sv
rtl/ftrg_if.sv
rtl/frame_time_resolution_governor_top.sv
dv/tb_frame_time_resolution_governor_top.sv
